FILE: sv/multi_event_interval_timer_unit_macros.svh
// Assertion helpers for the interval timer bank checker.
`ifndef MULTI_EVENT_INTERVAL_TIMER_UNIT_MACROS_SVH
`define MULTI_EVENT_INTERVAL_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEITU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEITU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/meitu_pkg.sv
package meitu_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int SLOT_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [3:0] CMD_TICK          = 4'd0;
    localparam logic [3:0] CMD_TICK_BY       = 4'd1;
    localparam logic [3:0] CMD_CREATE        = 4'd2;
    localparam logic [3:0] CMD_SET_INTERVAL  = 4'd3;
    localparam logic [3:0] CMD_RESET_SLOT    = 4'd4;
    localparam logic [3:0] CMD_RESET_ALL     = 4'd5;
    localparam logic [3:0] CMD_DISABLE       = 4'd6;
    localparam logic [3:0] CMD_ENABLE        = 4'd7;
    localparam logic [3:0] CMD_SET_REPEAT    = 4'd8;
    localparam logic [3:0] CMD_POLL          = 4'd9;
    localparam logic [3:0] CMD_QUERY_ACTIVE  = 4'd10;
    localparam logic [3:0] CMD_START         = 4'd11;
    localparam logic [3:0] CMD_STOP          = 4'd12;
    localparam logic [3:0] CMD_QUERY_ENABLED = 4'd13;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_REM  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  slot_id;
        logic [31:0] amount;
        logic        repeat_on;
        logic [15:0] repeat_limit;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]  slot_out;
        logic        flag_out;
        logic        active_out;
        logic        running_out;
        logic [1:0]  status;
        logic [15:0] pending_mask;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] interval;
        logic [31:0] count;
        logic        repeating;
        logic [15:0] rep_limit;
        logic [15:0] rep_count;
    } slot_word_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SLOT = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

FILE: sv/multi_event_interval_timer_unit.sv
// Multi-slot interval timer bank.
// Command channel (cmd_valid / cmd_stall / cmd_data): one command per transfer.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// command, in command order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// is the plain tick step, index 1 the drop-remainder bit; always ready.
// Start/stop, poll, enable/disable and queries respond straight from the done
// state; create, set_interval, reset_slot and set_repeat pass through the slot
// state (one slot memory read, one write-back); tick and tick_by on a running
// bank, and reset_all, walk the slots once a slot exists, as every created slot
// passes once through the slot memory read, a sum stage and a compare/write-back
// stage; with no slot created, or a stopped bank for ticks, no slot is walked.
// One command is worked on at a time; cmd_stall is high from the cycle after a
// transfer until the response is loaded into the output register.
// The next command is taken while an earlier response still waits to be taken.
// Reset: bank stopped, no slots created, all flags and active bits cleared,
// tick step 1, remainder kept. Slot memory needs no clearing pass: a slot's
// word is written in full when the slot is created.
// A stalled response holds its payload; the next finished response waits in
// the done state until the output register is free.
module multi_event_interval_timer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  meitu_pkg::cmd_item_t                cmd_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output meitu_pkg::rsp_item_t                rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [meitu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [meitu_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import meitu_pkg::*;

    localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam int MASK_W = (MAX_EVENTS > 16) ? MAX_EVENTS : 16;

    // configuration
    logic [15:0] tick_step_reg;
    logic        drop_rem_reg;

    // bank state in flops
    state_t                 state_reg;
    logic [CNT_W-1:0]       slots_used_reg;
    logic                   running_reg;
    logic [MAX_EVENTS-1:0]  active_reg;
    logic [MAX_EVENTS-1:0]  fired_reg;

    // latched command
    logic [3:0]             cmd_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [31:0]            amount_reg;
    logic                   rep_on_reg;
    logic [15:0]            rep_lim_reg;
    logic [15:0]            step_reg;
    logic                   walk_clear_reg;

    // result fields gathered while working
    logic [3:0]             res_slot_reg;
    logic                   res_flag_reg;
    logic                   res_active_reg;
    logic [1:0]             res_status_reg;

    // slot memory, registered read
    slot_word_t             mem [MAX_EVENTS];
    slot_word_t             mem_q;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    slot_word_t             wr_data;

    // walk pipeline
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic                   s1_v_reg;
    logic [SLOT_W-1:0]      s1_idx_reg;
    logic                   s2_v_reg;
    logic [SLOT_W-1:0]      s2_idx_reg;
    logic [32:0]            s2_sum_reg;
    slot_word_t             s2_word_reg;

    logic                   out_v_reg;
    rsp_item_t              out_reg;

    logic                   cmd_fire;
    logic                   issue;
    logic                   walk_end;
    logic [SLOT_W-1:0]      in_idx;
    logic                   in_valid_slot;
    logic                   in_per_slot;
    logic                   full;

    // write-back stage arithmetic
    logic [33:0]            diff;
    logic                   fire;
    logic [31:0]            rem;
    logic [15:0]            rc_inc;
    logic                   s2_keep_active;
    logic                   s2_we;

    logic [MASK_W-1:0]      fired_w;

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign rsp_valid = out_v_reg;
    assign rsp_data  = out_reg;

    assign in_idx        = SLOT_W'(cmd_data.slot_id);
    assign in_valid_slot = CMP_W'(cmd_data.slot_id) < CMP_W'(slots_used_reg);
    assign full          = (slots_used_reg == CNT_W'(MAX_EVENTS));

    always_comb
    begin
        case (cmd_data.cmd) inside
            CMD_SET_INTERVAL, CMD_RESET_SLOT, [CMD_DISABLE:CMD_QUERY_ACTIVE]:
                in_per_slot = 1'b1;
            default:
                in_per_slot = 1'b0;
        endcase
    end

    assign issue    = (state_reg == ST_WALK) && (rd_cnt_reg != slots_used_reg);
    assign walk_end = (state_reg == ST_WALK) && !issue && !s1_v_reg && !s2_v_reg;
    assign rd_addr  = (state_reg == ST_IDLE) ? in_idx : rd_cnt_reg[SLOT_W-1:0];

    // compare / remainder stage
    assign diff = {1'b0, s2_sum_reg} - {2'b00, s2_word_reg.interval};
    assign fire = !diff[33];
    always_comb
    begin
        if (drop_rem_reg)
            rem = 32'd0;
        else if (diff[32])
            rem = 32'hFFFF_FFFF;
        else
            rem = diff[31:0];
    end
    assign rc_inc = (s2_word_reg.rep_count != 16'hFFFF) ?
                    s2_word_reg.rep_count + 16'd1 : s2_word_reg.rep_count;

    always_comb
    begin
        s2_keep_active = 1'b1;
        if (fire)
        begin
            if (!s2_word_reg.repeating)
                s2_keep_active = 1'b0;
            else if (s2_word_reg.rep_limit != 16'd0 && rc_inc >= s2_word_reg.rep_limit)
                s2_keep_active = 1'b0;
        end
    end

    assign s2_we = s2_v_reg && (walk_clear_reg || active_reg[s2_idx_reg]);

    // memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = mem_q;
        if (state_reg == ST_SLOT)
        begin
            case (cmd_reg)
                CMD_CREATE:
                begin
                    wr_en             = 1'b1;
                    wr_addr           = slots_used_reg[SLOT_W-1:0];
                    wr_data.interval  = amount_reg;
                    wr_data.count     = 32'd0;
                    wr_data.repeating = rep_on_reg;
                    wr_data.rep_limit = rep_on_reg ? rep_lim_reg : 16'd0;
                    wr_data.rep_count = 16'd0;
                end
                CMD_SET_INTERVAL:
                begin
                    wr_en            = 1'b1;
                    wr_data.interval = amount_reg;
                end
                CMD_RESET_SLOT:
                begin
                    wr_en             = 1'b1;
                    wr_data.count     = 32'd0;
                    wr_data.rep_count = 16'd0;
                end
                CMD_SET_REPEAT:
                begin
                    wr_en             = 1'b1;
                    wr_data.repeating = rep_on_reg;
                    wr_data.rep_limit = rep_lim_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_WALK)
        begin
            wr_en   = s2_we;
            wr_addr = s2_idx_reg;
            wr_data = s2_word_reg;
            if (walk_clear_reg)
            begin
                wr_data.count     = 32'd0;
                wr_data.rep_count = 16'd0;
            end
            else if (fire)
            begin
                wr_data.count = rem;
                if (s2_word_reg.repeating && s2_word_reg.rep_limit != 16'd0)
                    wr_data.rep_count = rc_inc;
            end
            else
            begin
                wr_data.count = s2_sum_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // walk pipeline payload: read -> sum -> write-back
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_cnt_reg[SLOT_W-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_word_reg <= mem_q;
        s2_sum_reg  <= {1'b0, mem_q.count} + 33'(step_reg);
    end

    // latched command payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg        <= cmd_data.cmd;
            idx_reg        <= in_idx;
            amount_reg     <= cmd_data.amount;
            rep_on_reg     <= cmd_data.repeat_on;
            rep_lim_reg    <= cmd_data.repeat_limit;
            step_reg       <= (cmd_data.cmd == CMD_TICK) ? tick_step_reg
                                                         : cmd_data.amount[15:0];
            walk_clear_reg <= (cmd_data.cmd == CMD_RESET_ALL);
        end
    end

    assign fired_w = MASK_W'(fired_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg  <= 16'd1;
            drop_rem_reg   <= 1'b0;
            state_reg      <= ST_IDLE;
            slots_used_reg <= '0;
            running_reg    <= 1'b0;
            active_reg     <= '0;
            fired_reg      <= '0;
            rd_cnt_reg     <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            res_slot_reg   <= '0;
            res_flag_reg   <= 1'b0;
            res_active_reg <= 1'b0;
            res_status_reg <= STAT_OK;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TICK_STEP)
                    tick_step_reg <= cfg_data[15:0];
                else if (cfg_index == CFG_DROP_REM)
                    drop_rem_reg <= cfg_data[0];
            end

            if (out_v_reg && !rsp_stall)
                out_v_reg <= 1'b0;

            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        res_slot_reg   <= cmd_data.slot_id;
                        res_flag_reg   <= 1'b0;
                        res_active_reg <= 1'b0;
                        res_status_reg <= STAT_OK;
                        rd_cnt_reg     <= '0;
                        state_reg      <= ST_DONE;
                        if (in_per_slot && !in_valid_slot)
                        begin
                            res_status_reg <= STAT_NO_SLOT;
                        end
                        else
                        begin
                            case (cmd_data.cmd)
                                CMD_TICK, CMD_TICK_BY:
                                begin
                                    if (running_reg && slots_used_reg != '0)
                                        state_reg <= ST_WALK;
                                end
                                CMD_CREATE:
                                begin
                                    if (full)
                                    begin
                                        res_status_reg <= STAT_FULL;
                                        res_slot_reg   <= 4'd0;
                                    end
                                    else
                                    begin
                                        res_slot_reg <= 4'(slots_used_reg);
                                        state_reg    <= ST_SLOT;
                                    end
                                end
                                CMD_SET_INTERVAL, CMD_SET_REPEAT:
                                    state_reg <= ST_SLOT;
                                CMD_RESET_SLOT:
                                begin
                                    active_reg[in_idx] <= 1'b1;
                                    fired_reg[in_idx]  <= 1'b0;
                                    state_reg          <= ST_SLOT;
                                end
                                CMD_RESET_ALL:
                                begin
                                    if (slots_used_reg != '0)
                                        state_reg <= ST_WALK;
                                end
                                CMD_DISABLE:
                                    active_reg[in_idx] <= 1'b0;
                                CMD_ENABLE:
                                    active_reg[in_idx] <= 1'b1;
                                CMD_POLL:
                                begin
                                    res_flag_reg      <= fired_reg[in_idx];
                                    fired_reg[in_idx] <= 1'b0;
                                end
                                CMD_QUERY_ACTIVE:
                                    res_active_reg <= active_reg[in_idx];
                                CMD_START:
                                    running_reg <= 1'b1;
                                CMD_STOP:
                                    running_reg <= 1'b0;
                                default:
                                begin
                                    // query_enabled and unused codes: echo only
                                end
                            endcase
                        end
                    end
                end

                ST_SLOT:
                begin
                    if (cmd_reg == CMD_CREATE)
                    begin
                        active_reg[slots_used_reg[SLOT_W-1:0]] <= 1'b1;
                        fired_reg[slots_used_reg[SLOT_W-1:0]]  <= 1'b0;
                        slots_used_reg <= slots_used_reg + CNT_W'(1);
                    end
                    state_reg <= ST_DONE;
                end

                ST_WALK:
                begin
                    if (issue)
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    if (s2_we)
                    begin
                        if (walk_clear_reg)
                        begin
                            active_reg[s2_idx_reg] <= 1'b1;
                            fired_reg[s2_idx_reg]  <= 1'b0;
                        end
                        else if (fire)
                        begin
                            fired_reg[s2_idx_reg]  <= 1'b1;
                            active_reg[s2_idx_reg] <= s2_keep_active;
                        end
                    end
                    if (walk_end)
                        state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!out_v_reg || !rsp_stall)
                    begin
                        out_v_reg           <= 1'b1;
                        out_reg.slot_out     <= res_slot_reg;
                        out_reg.flag_out     <= res_flag_reg;
                        out_reg.active_out   <= res_active_reg;
                        out_reg.running_out  <= running_reg;
                        out_reg.status       <= res_status_reg;
                        out_reg.pending_mask <= fired_w[15:0];
                        state_reg            <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/meitu_checker.sv
`include "multi_event_interval_timer_unit_macros.svh"

module meitu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_stall,
    input meitu_pkg::cmd_item_t cmd_data,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input meitu_pkg::rsp_item_t rsp_data
);
    import meitu_pkg::*;

    // one command in flight: busy from the cycle after a transfer
    `MEITU_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall, "command taken while busy")
    // stalled response holds
    `MEITU_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
    // errors carry no flag or active bit
    `MEITU_ASSERT_NOW(a_err_clean, clk, rst_n, rsp_valid && rsp_data.status != STAT_OK, !rsp_data.flag_out && !rsp_data.active_out, "error response with flag or active set")
    // full table reports slot 0, and no undefined status code
    `MEITU_ASSERT_NOW(a_full_slot, clk, rst_n, rsp_valid && (rsp_data.status == STAT_FULL || rsp_data.status == 2'd3), rsp_data.status == STAT_FULL && rsp_data.slot_out == 4'd0, "bad full-table response")

endmodule

bind multi_event_interval_timer_unit meitu_checker u_meitu_checker (.*);

FILE: test/multi_event_interval_timer_unit_tb.sv
module multi_event_interval_timer_unit_tb;
    import meitu_pkg::*;

    // Cycles without any transfer before the run is abandoned.
    localparam int QUIET_LIMIT    = 5000;
    // A tick on a full table walks 16 slots plus the pipeline; allow a little more.
    localparam int SETTLE_CYCLES  = 24;
    // Receiver hold-off long enough for the block to back up onto its input.
    localparam int LONG_HOLD      = 400;
    // Directed ticks of step 0xFFFF on the two interval-0 slots: both fire on
    // every one and slot 0's kept remainder climbs by 0xFFFF each time.
    localparam int RUN_TICKS      = 16;

    // Codes that the bank must ignore.
    localparam logic [3:0]           CMD_SPARE_LO   = 4'd14;
    localparam logic [3:0]           CMD_SPARE_HI   = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(15);

    localparam int REPORT_LIMIT = 10;

    // Shadow of the timer bank: state, configuration and the queue of
    // responses still owed by the block, oldest first.
    class timer_bank_shadow;
        bit [15:0]       step_reg;
        bit              drop_rem;
        bit [CNT_W-1:0]  used;
        bit              running;
        bit [31:0]       interval [MAX_EVENTS];
        bit [31:0]       count [MAX_EVENTS];
        bit              active [MAX_EVENTS];
        bit              fired [MAX_EVENTS];
        bit              repeating [MAX_EVENTS];
        bit [15:0]       rep_limit [MAX_EVENTS];
        bit [15:0]       rep_count [MAX_EVENTS];
        rsp_item_t       responses_due [$];
        int              mismatches;

        function new();
            step_reg = 16'd1;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TICK_STEP)
                step_reg = val;
            else if (idx == CFG_DROP_REM)
                drop_rem = val[0];
        endfunction

        function void restart(int i);
            active[i]    = 1'b1;
            count[i]     = '0;
            fired[i]     = 1'b0;
            rep_count[i] = '0;
        endfunction

        // While the bank runs, every active slot gains step; a count at or over the interval fires.
        function void advance(bit [15:0] step);
            bit [32:0] sum;
            bit [32:0] rem;
            if (!running)
                return;
            for (int i = 0; i < used; i++)
            begin
                if (!active[i])
                    continue;
                sum = {1'b0, count[i]} + {17'd0, step};
                if (sum >= {1'b0, interval[i]})
                begin
                    rem = drop_rem ? 33'd0 : sum - {1'b0, interval[i]};
                    count[i] = rem[32] ? 32'hFFFF_FFFF : rem[31:0];
                    fired[i] = 1'b1;
                    if (!repeating[i])
                        active[i] = 1'b0;
                    else if (rep_limit[i] != 0)
                    begin
                        if (rep_count[i] != 16'hFFFF)
                            rep_count[i]++;
                        if (rep_count[i] >= rep_limit[i])
                            active[i] = 1'b0;
                    end
                end
                else
                    count[i] = sum[31:0];
            end
        endfunction

        function void take_command(cmd_item_t c);
            rsp_item_t r;
            bit        per_slot;
            int        k;
            r = '0;
            r.slot_out = c.slot_id;
            case (c.cmd)
                CMD_SET_INTERVAL, CMD_RESET_SLOT, CMD_DISABLE, CMD_ENABLE,
                CMD_SET_REPEAT, CMD_POLL, CMD_QUERY_ACTIVE: per_slot = 1'b1;
                default: per_slot = 1'b0;
            endcase
            if (per_slot && c.slot_id >= used)
                r.status = STAT_NO_SLOT;
            else
            begin
                case (c.cmd)
                    CMD_TICK:    advance(step_reg);
                    CMD_TICK_BY: advance(c.amount[15:0]);
                    CMD_CREATE:
                        if (used >= MAX_EVENTS)
                        begin
                            r.status   = STAT_FULL;
                            r.slot_out = '0;
                        end
                        else
                        begin
                            k = used;
                            interval[k]  = c.amount;
                            count[k]     = '0;
                            active[k]    = 1'b1;
                            fired[k]     = 1'b0;
                            repeating[k] = c.repeat_on;
                            rep_limit[k] = c.repeat_on ? c.repeat_limit : 16'd0;
                            rep_count[k] = '0;
                            used++;
                            r.slot_out = k[3:0];
                        end
                    CMD_SET_INTERVAL: interval[c.slot_id] = c.amount;
                    CMD_RESET_SLOT:   restart(c.slot_id);
                    CMD_RESET_ALL:
                        for (int i = 0; i < used; i++)
                            restart(i);
                    CMD_DISABLE: active[c.slot_id] = 1'b0;
                    CMD_ENABLE:  active[c.slot_id] = 1'b1;
                    CMD_SET_REPEAT:
                    begin
                        repeating[c.slot_id] = c.repeat_on;
                        rep_limit[c.slot_id] = c.repeat_limit;
                    end
                    CMD_POLL:
                    begin
                        r.flag_out = fired[c.slot_id];
                        fired[c.slot_id] = 1'b0;
                    end
                    CMD_QUERY_ACTIVE: r.active_out = active[c.slot_id];
                    CMD_START:        running = 1'b1;
                    CMD_STOP:         running = 1'b0;
                    default: ;
                endcase
            end
            r.running_out = running;
            for (int i = 0; i < MAX_EVENTS && i < 16; i++)
                r.pending_mask[i] = fired[i];
            responses_due.push_back(r);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (responses_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response with none outstanding: %h", got);
                return;
            end
            want = responses_due.pop_front();
            if (got.slot_out !== want.slot_out || got.flag_out !== want.flag_out ||
                got.active_out !== want.active_out || got.running_out !== want.running_out ||
                got.status !== want.status || got.pending_mask !== want.pending_mask)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $write("mismatch (exp/got): slot %0d/%0d flag %b/%b active %b/%b",
                           want.slot_out, got.slot_out, want.flag_out, got.flag_out,
                           want.active_out, got.active_out);
                    $display(" running %b/%b status %0d/%0d mask %h/%h",
                             want.running_out, got.running_out, want.status, got.status,
                             want.pending_mask, got.pending_mask);
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_item_t             cmd_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    timer_bank_shadow board;
    int tx_idle_pct  = 18;
    int rx_idle_pct  = 67;
    bit hold_req     = 1'b0;
    bit hold_seen    = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    multi_event_interval_timer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Receiver: random stalls, or a long hold-off when one is requested.
    // The hold is counted here so the sender keeps offering meanwhile.
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_left = LONG_HOLD;
            hold_seen = 1'b1;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Response transfers are checked against the oldest outstanding prediction.
    // Sampled values here are those the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp_data);
    end

    // Watchdog: a long stretch with no transfer on any channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One command transfer. Valid stays high from the previous transfer if no
    // idle cycle is drawn, so a back-to-back stream never drops valid.
    task automatic send_command(input logic [3:0] op, input logic [3:0] id,
                                input logic [31:0] amt, input logic rep,
                                input logic [15:0] lim);
        cmd_item_t c;
        c.cmd          = op;
        c.slot_id      = id;
        c.amount       = amt;
        c.repeat_on    = rep;
        c.repeat_limit = lim;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.take_command(c);
    endtask

    // Register write; one spare cycle afterwards keeps the lowering of valid
    // apart from the next write's raising of it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.write_register(idx, val);
        @(posedge clk);
    endtask

    // Wait for every owed response, then let the pipeline empty.
    task automatic drain_bank();
        cmd_valid <= 1'b0;
        while (board.responses_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Intervals: mostly short so slots fire often, some long, some extreme.
    function automatic logic [31:0] pick_interval();
        int p;
        p = $urandom_range(9);
        if (p < 6)
            return $urandom_range(0, 40);
        else if (p < 8)
            return $urandom_range(0, 32'h1_FFFF);
        else if (p == 8)
            return $urandom();
        else
            return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    // Random commands, weighted towards ticks and polls so slots keep firing
    // and flags keep being collected; ids mostly land on created slots.
    task automatic run_random(input int n);
        logic [3:0]  op;
        logic [3:0]  id;
        logic [31:0] amt;
        logic        rep;
        logic [15:0] lim;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)      op = CMD_TICK;
            else if (pick < 36) op = CMD_TICK_BY;
            else if (pick < 42) op = CMD_CREATE;
            else if (pick < 48) op = CMD_SET_INTERVAL;
            else if (pick < 53) op = CMD_RESET_SLOT;
            else if (pick < 55) op = CMD_RESET_ALL;
            else if (pick < 60) op = CMD_DISABLE;
            else if (pick < 67) op = CMD_ENABLE;
            else if (pick < 73) op = CMD_SET_REPEAT;
            else if (pick < 85) op = CMD_POLL;
            else if (pick < 90) op = CMD_QUERY_ACTIVE;
            else if (pick < 94) op = CMD_START;
            else if (pick < 95) op = CMD_STOP;
            else if (pick < 98) op = CMD_QUERY_ENABLED;
            else if (pick < 99) op = CMD_SPARE_LO;
            else                op = CMD_SPARE_HI;

            if (board.used != 0 && $urandom_range(9) != 0)
                id = 4'($urandom_range(board.used - 1));
            else
                id = 4'($urandom_range(15));

            amt = $urandom();
            if (op == CMD_CREATE || op == CMD_SET_INTERVAL)
                amt = pick_interval();
            else if (op == CMD_TICK_BY && $urandom_range(4) != 0)
                amt[15:0] = 16'($urandom_range(0, 12));

            rep = 1'($urandom_range(1));
            lim = ($urandom_range(9) < 7) ? 16'($urandom_range(0, 4)) : 16'($urandom());
            send_command(op, id, amt, rep, lim);
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: per-slot commands are refused, ticks do nothing.
        send_command(CMD_QUERY_ACTIVE, 4'd0, 32'h0, 1'b0, 16'h0);
        send_command(CMD_POLL, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_command(CMD_TICK, 4'd7, 32'h0, 1'b0, 16'h0);
        send_command(CMD_SPARE_LO, 4'd3, 32'h0, 1'b0, 16'h0);
        send_command(CMD_SPARE_HI, 4'd12, 32'h0, 1'b0, 16'h0);

        // Slot 0 repeats without limit, slot 1 carries the largest limit;
        // both fire on every tick since their interval is 0.
        send_command(CMD_CREATE, 4'd9, 32'h0, 1'b1, 16'h0);
        send_command(CMD_CREATE, 4'd0, 32'h0, 1'b1, 16'hFFFF);
        send_command(CMD_SET_INTERVAL, 4'd2, 32'hFFFF_FFFF, 1'b0, 16'h0);
        send_command(CMD_TICK_BY, 4'd0, 32'h5, 1'b0, 16'h0);  // bank still stopped
        send_command(CMD_START, 4'd0, 32'h0, 1'b0, 16'h0);

        // Run of wide steps: slot 0's kept remainder grows by 0xFFFF per tick
        // and slot 1's repeat count climbs towards its limit.
        for (int k = 0; k < RUN_TICKS; k++)
            send_command(CMD_TICK_BY, 4'($urandom_range(15)), $urandom() | 32'h0000_FFFF,
                         1'b0, 16'h0);

        send_command(CMD_QUERY_ACTIVE, 4'd1, 32'h0, 1'b0, 16'h0);
        send_command(CMD_QUERY_ACTIVE, 4'd0, 32'h0, 1'b0, 16'h0);
        send_command(CMD_POLL, 4'd0, 32'h0, 1'b0, 16'h0);
        send_command(CMD_POLL, 4'd0, 32'h0, 1'b0, 16'h0);  // flag already cleared
        send_command(CMD_SET_REPEAT, 4'd1, 32'h0, 1'b1, 16'd3);
        send_command(CMD_RESET_ALL, 4'd0, 32'h0, 1'b0, 16'h0);
        send_command(CMD_STOP, 4'd0, 32'h0, 1'b0, 16'h0);
        send_command(CMD_TICK, 4'd0, 32'h0, 1'b0, 16'h0);  // stopped, no effect
        send_command(CMD_QUERY_ENABLED, 4'd1, 32'h0, 1'b0, 16'h0);
        // One-shot create: the limit given is discarded.
        send_command(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        send_command(CMD_DISABLE, 4'd2, 32'h0, 1'b0, 16'h0);
        send_command(CMD_ENABLE, 4'd2, 32'h0, 1'b0, 16'h0);
        send_command(CMD_RESET_SLOT, 4'd1, 32'h0, 1'b0, 16'h0);
        send_command(CMD_START, 4'd0, 32'h0, 1'b0, 16'h0);

        // Random phases; each register setting is applied with the bank idle.
        drain_bank();
        write_register(CFG_TICK_STEP, 16'd0);
        write_register(CFG_DROP_REM, 16'd1);
        run_random(160);

        drain_bank();
        write_register(CFG_TICK_STEP, 16'd1);
        write_register(CFG_DROP_REM, 16'd0);
        write_register(CFG_UNUSED_IDX, 16'hFFFF);
        run_random(160);

        tx_idle_pct = 67;
        rx_idle_pct = 18;
        drain_bank();
        write_register(CFG_TICK_STEP, 16'hFFFF);
        write_register(CFG_DROP_REM, 16'd1);
        run_random(150);

        drain_bank();
        write_register(CFG_TICK_STEP, 16'($urandom_range(2, 9)));
        write_register(CFG_DROP_REM, 16'd0);
        run_random(150);

        // No idling; the receiver holds off for a while so the block backs up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_bank();
        write_register(CFG_TICK_STEP, 16'd3);
        write_register(CFG_DROP_REM, 16'd1);
        hold_req = 1'b1;
        run_random(150);

        drain_bank();
        write_register(CFG_TICK_STEP, 16'd1);
        write_register(CFG_DROP_REM, 16'd0);
        run_random(150);

        drain_bank();
        if (board.mismatches == 0 && board.responses_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/meitu_pkg.sv
sv/multi_event_interval_timer_unit.sv
sv/meitu_checker.sv
test/multi_event_interval_timer_unit_tb.sv
